// ===== rtl/lea_pkg.sv =====
// Package of shared constants and codes for the Laplacian energy accumulator.
`default_nettype none

package lea_pkg;

  // Default line store depth and frame height limit.
  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  // Configuration register geometry and reset values.
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Payload widths.
  localparam int PIXEL_W = 8;
  localparam int SUM_W   = 35;
  localparam int SUM_SQ_W = 44;
  localparam int COUNT_W = 24;
  localparam int LAP_W   = 11;
  localparam int SQ_W    = 20;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/lea_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none

module lea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read that returns the contents before a same-edge write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/laplacian_energy_accumulator_unit.sv =====
// Top level of the Laplacian energy accumulator: line stores, window and frame sums.
// One pixel is accepted per cycle unless input is held off; the work for it is one add
// tree, one 10x10 square and one wide add, done at the edge that accepts it. The frame
// result is loaded into the output register at the edge that accepts the last pixel and
// is offered next cycle. Input is held off while a result is stalled, and in the cycle
// after each configuration write while the line store read is refetched. Synchronous
// reset clears positions, window, sums and handshakes.
`default_nettype none

module laplacian_energy_accumulator_unit #(
  parameter int MAX_WIDTH  = lea_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = lea_pkg::DEFAULT_MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Pixel channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [lea_pkg::PIXEL_W-1:0]      pixel,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  stats_valid,
  output logic signed [lea_pkg::SUM_W-1:0]      lap_sum,
  output logic      [lea_pkg::SUM_SQ_W-1:0]     lap_sum_sq,
  output logic      [lea_pkg::COUNT_W-1:0]      interior_count,
  // Configuration write channel.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lea_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lea_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = lea_pkg::CFG_DATA_W;
  localparam int XW = ((CW + 1) > DW) ? (CW + 1) : DW;
  localparam int YW = ((RW + 1) > DW) ? (RW + 1) : DW;
  localparam int PW = CW + RW + 2;
  localparam int PXW = lea_pkg::PIXEL_W;
  localparam int LW = lea_pkg::LAP_W;
  localparam int SW = lea_pkg::SUM_W;
  localparam int QW = lea_pkg::SUM_SQ_W;
  localparam int NW = lea_pkg::COUNT_W;
  localparam int SQW = lea_pkg::SQ_W;

  // Configuration registers.
  logic [DW-1:0] frame_width;
  logic [DW-1:0] frame_height;
  logic          refetch;

  // Frame position and window.
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [PXW-1:0] tap0;
  logic [PXW-1:0] tap1;
  logic [PXW-1:0] tap2;

  // Copies of the last beat's writes for forwarding.
  logic           last_accept;
  logic           fwd;
  logic [PXW-1:0] px_q;
  logic [PXW-1:0] above_q;

  // Running sums.
  logic [SW-1:0] acc_sum;
  logic [QW-1:0] acc_sum_sq;

  assign cfg_ready = 1'b1;

  // Configuration writes; a write holds off pixel input in the cycle after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lea_pkg::FRAME_WIDTH_RESET;
      frame_height <= lea_pkg::FRAME_HEIGHT_RESET;
      refetch      <= 1'b0;
    end else begin
      refetch <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lea_pkg::REG_FRAME_WIDTH) begin
          frame_width <= cfg_data;
        end
        if (cfg_index == lea_pkg::REG_FRAME_HEIGHT) begin
          frame_height <= cfg_data;
        end
      end
    end
  end

  // Effective frame size: zero counts as one, large values saturate.
  logic [XW-1:0] w_wide;
  logic [YW-1:0] h_wide;
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;

  always_comb begin
    w_wide = {{(XW-DW){1'b0}}, frame_width};
    h_wide = {{(YW-DW){1'b0}}, frame_height};
    if (frame_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (w_wide > XW'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = w_wide[CW:0];
    end
    if (frame_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (h_wide > YW'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = h_wide[RW:0];
    end
  end

  assign w_last = CW'(w_eff - (CW+1)'(1));
  assign h_last = RW'(h_eff - (RW+1)'(1));

  // Current position, clamped to the frame in force.
  logic [CW-1:0] c_eff;
  logic [RW-1:0] r_eff;
  logic          row_end;
  logic          frame_end;
  logic          accept;
  logic [CW-1:0] c_next;
  logic [CW-1:0] rd_addr;

  assign c_eff     = (col > w_last) ? w_last : col;
  assign r_eff     = (row > h_last) ? h_last : row;
  assign row_end   = (c_eff == w_last);
  assign frame_end = row_end && (r_eff == h_last);
  assign in_stall  = refetch || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign c_next    = row_end ? '0 : c_eff + CW'(1);
  assign rd_addr   = accept ? c_next : c_eff;

  // Line stores; the left neighbour copy of the recent row is read one column back.
  logic [PXW-1:0] recent_rd;
  logic [PXW-1:0] recent_left_rd;
  logic [PXW-1:0] older_rd;
  logic [PXW-1:0] above;
  logic [PXW-1:0] above2;
  logic [PXW-1:0] below;

  lea_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_recent (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (c_eff),
    .wr_data (pixel),
    .rd_addr (rd_addr),
    .rd_data (recent_rd)
  );

  lea_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_recent_left (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (c_eff),
    .wr_data (pixel),
    .rd_addr (rd_addr - CW'(1)),
    .rd_data (recent_left_rd)
  );

  lea_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (c_eff),
    .wr_data (above),
    .rd_addr (rd_addr),
    .rd_data (older_rd)
  );

  // Forward the last beat's writes where the read could not yet see them.
  assign above  = fwd ? px_q : recent_rd;
  assign above2 = fwd ? above_q : older_rd;

  always_comb begin
    if (c_eff == '0) begin
      below = '0;
    end else if (last_accept) begin
      below = px_q;
    end else begin
      below = recent_left_rd;
    end
  end

  // Laplacian of the pixel one row up and one column left, and its square.
  logic [PXW+1:0]        nb_sum;
  logic signed [LW-1:0]  lap;
  logic [LW-2:0]         lap_mag;
  logic [SQW-1:0]        lap_sq;
  logic                  interior;
  logic [SW-1:0]         sum_add;
  logic [QW-1:0]         sq_add;

  always_comb begin
    nb_sum  = {2'b00, tap2} + {2'b00, below} + {2'b00, tap0} + {2'b00, above};
    lap     = $signed({1'b0, nb_sum}) - $signed({1'b0, tap1, 2'b00});
    lap_mag = lap[LW-1] ? (LW-1)'(-lap) : (LW-1)'(lap);
    lap_sq  = lap_mag * lap_mag;
    interior = (r_eff >= RW'(2)) && (c_eff >= CW'(2));
    sum_add = interior ? {{(SW-LW){lap[LW-1]}}, lap} : '0;
    sq_add  = interior ? {{(QW-SQW){1'b0}}, lap_sq} : '0;
  end

  // Interior count for the frame in force.
  logic [PW-1:0]    count_full;
  logic [PW+NW-1:0] count_pad;

  always_comb begin
    count_full = '0;
    if (w_eff >= (CW+1)'(3) && h_eff >= (RW+1)'(3)) begin
      count_full = PW'(w_eff - (CW+1)'(2)) * PW'(h_eff - (RW+1)'(2));
    end
    count_pad = {{NW{1'b0}}, count_full};
  end

  // Position, window and sums advance on each accepted beat; the forwarding flags update on every clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      tap0        <= '0;
      tap1        <= '0;
      tap2        <= '0;
      last_accept <= 1'b0;
      fwd         <= 1'b0;
      acc_sum     <= '0;
      acc_sum_sq  <= '0;
    end else begin
      last_accept <= accept;
      fwd         <= accept && (c_next == c_eff);
      if (accept) begin
        col  <= c_next;
        tap0 <= tap1;
        tap1 <= above;
        tap2 <= above2;
        if (row_end) begin
          row <= frame_end ? '0 : r_eff + RW'(1);
        end
        if (frame_end) begin
          acc_sum    <= '0;
          acc_sum_sq <= '0;
        end else begin
          acc_sum    <= acc_sum + sum_add;
          acc_sum_sq <= acc_sum_sq + sq_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_q    <= pixel;
      above_q <= above;
    end
  end

  // Result register; a new frame result may load as the previous one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && frame_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      stats_valid    <= (count_full >= PW'(2));
      lap_sum        <= $signed(acc_sum + sum_add);
      lap_sum_sq     <= acc_sum_sq + sq_add;
      interior_count <= count_pad[NW-1:0];
    end
  end

endmodule

`default_nettype wire
